// ===== sv/lcni_pkg.sv =====
`default_nettype none

package lcni_pkg;

  localparam int unsigned COORD_WIDTH     = 32;
  localparam int unsigned DIFF_WIDTH      = COORD_WIDTH + 1;
  localparam int unsigned PROD_WIDTH      = 2 * DIFF_WIDTH;
  localparam int unsigned MAG_WIDTH       = 2 * COORD_WIDTH + 5;
  localparam int unsigned DISC_WIDTH      = 2 * MAG_WIDTH;
  localparam int unsigned NUMER_WIDTH     = MAG_WIDTH + DIFF_WIDTH;
  localparam int unsigned QUOT_WIDTH      = DIFF_WIDTH;
  localparam int unsigned MUL_DIGIT_DEF   = 16;
  localparam int unsigned CFG_INDEX_WIDTH = 2;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_CENTRE_X,
    CFG_CENTRE_Y,
    CFG_RIM_X,
    CFG_RIM_Y
  } cfg_index_e;

  typedef enum logic [1:0] {
    STATUS_TWO_ROOTS,
    STATUS_TANGENT,
    STATUS_NO_HIT,
    STATUS_ZERO_LINE
  } status_e;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } line_t;

  typedef struct packed {
    coord_t  hit_x;
    coord_t  hit_y;
    status_e status;
  } hit_t;

endpackage

`default_nettype wire

// ===== sv/lcni_mul2.sv =====
`default_nettype none

module lcni_mul2 #(
  parameter int unsigned WA = 24,
  parameter int unsigned WB = 24,
  parameter int unsigned DIG = 8,
  parameter type side_t = logic
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  side_t          side_i,
  input  logic [WA-1:0]  a0_i,
  input  logic [WB-1:0]  b0_i,
  input  logic [WA-1:0]  a1_i,
  input  logic [WB-1:0]  b1_i,
  output logic           valid_o,
  output side_t          side_o,
  output logic [WA+WB-1:0] p0_o,
  output logic [WA+WB-1:0] p1_o
);

  localparam int unsigned NS  = (WB + DIG - 1) / DIG;
  localparam int unsigned BW  = NS * DIG;
  localparam int unsigned PW  = WA + WB;
  localparam int unsigned MPW = WA + DIG;

  typedef struct packed {
    logic [WA-1:0] a;
    logic [BW-1:0] b;
    logic [PW-1:0] acc;
  } lane_t;

  function automatic lane_t step(lane_t x, int unsigned sh);
    lane_t          r;
    logic [MPW-1:0] prod;
    prod  = MPW'(x.a) * MPW'(x.b[DIG-1:0]);
    r.a   = x.a;
    r.b   = x.b >> DIG;
    r.acc = x.acc + (PW'(prod) << sh);
    return r;
  endfunction

  logic  vld_q   [1:NS];
  side_t side_q  [1:NS];
  lane_t lane0_q [1:NS];
  lane_t lane1_q [1:NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic  vld;
    side_t side;
    lane_t src0, src1;

    if (s == 0) begin : g_first
      assign vld  = valid_i;
      assign side = side_i;
      assign src0 = '{a: a0_i, b: BW'(b0_i), acc: '0};
      assign src1 = '{a: a1_i, b: BW'(b1_i), acc: '0};
    end else begin : g_next
      assign vld  = vld_q[s];
      assign side = side_q[s];
      assign src0 = lane0_q[s];
      assign src1 = lane1_q[s];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s+1]  <= side;
        lane0_q[s+1] <= step(src0, s * DIG);
        lane1_q[s+1] <= step(src1, s * DIG);
      end
    end
  end

  assign valid_o = vld_q[NS];
  assign side_o  = side_q[NS];
  assign p0_o    = lane0_q[NS].acc;
  assign p1_o    = lane1_q[NS].acc;

endmodule

`default_nettype wire

// ===== sv/lcni_sqrt.sv =====
`default_nettype none

module lcni_sqrt #(
  parameter int unsigned VW = 16,
  parameter type side_t = logic
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  side_t           side_i,
  input  logic [VW-1:0]   value_i,
  output logic            valid_o,
  output side_t           side_o,
  output logic [VW/2-1:0] root_o
);

  localparam int unsigned RW  = VW / 2;
  localparam int unsigned RMW = RW + 2;

  typedef struct packed {
    logic [VW-1:0]  v;
    logic [RMW-1:0] rem;
    logic [RW-1:0]  root;
  } st_t;

  function automatic st_t step(st_t x);
    st_t              r;
    logic [RMW+1:0]   rs;
    logic [RMW+1:0]   tr;
    logic             ge;
    rs     = {x.rem, x.v[VW-1:VW-2]};
    tr     = (RMW+2)'({x.root, 2'b01});
    ge     = rs >= tr;
    r.rem  = ge ? RMW'(rs - tr) : RMW'(rs);
    r.root = {x.root[RW-2:0], ge};
    r.v    = x.v << 2;
    return r;
  endfunction

  logic  vld_q  [1:RW];
  side_t side_q [1:RW];
  st_t   st_q   [1:RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic  vld;
    side_t side;
    st_t   src;

    if (s == 0) begin : g_first
      assign vld  = valid_i;
      assign side = side_i;
      assign src  = '{v: value_i, rem: '0, root: '0};
    end else begin : g_next
      assign vld  = vld_q[s];
      assign side = side_q[s];
      assign src  = st_q[s];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s+1] <= side;
        st_q[s+1]   <= step(src);
      end
    end
  end

  assign valid_o = vld_q[RW];
  assign side_o  = side_q[RW];
  assign root_o  = st_q[RW].root;

endmodule

`default_nettype wire

// ===== sv/lcni_div2.sv =====
`default_nettype none

module lcni_div2 #(
  parameter int unsigned NW = 24,
  parameter int unsigned DW = 16,
  parameter int unsigned QW = 8,
  parameter type side_t = logic
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  side_t         side_i,
  input  logic [NW-1:0] n0_i,
  input  logic [NW-1:0] n1_i,
  input  logic [DW-1:0] d_i,
  output logic          valid_o,
  output side_t         side_o,
  output logic [QW-1:0] q0_o,
  output logic [QW-1:0] q1_o,
  output logic          ovf0_o,
  output logic          ovf1_o
);

  localparam int unsigned HW = NW - QW;
  localparam int unsigned CW = (HW > DW) ? HW : DW;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] nb;
    logic [QW-1:0] q;
    logic          ovf;
  } lane_t;

  function automatic lane_t load(logic [NW-1:0] n, logic [DW-1:0] d);
    lane_t         r;
    logic [HW-1:0] hi;
    hi    = n[NW-1:QW];
    r.ovf = CW'(hi) >= CW'(d);
    r.rem = DW'(hi);
    r.nb  = n[QW-1:0];
    r.q   = '0;
    return r;
  endfunction

  function automatic lane_t step(lane_t x, logic [DW-1:0] d);
    lane_t       r;
    logic [DW:0] rs;
    logic        ge;
    rs    = {x.rem, x.nb[QW-1]};
    ge    = rs >= {1'b0, d};
    r.rem = ge ? DW'(rs - {1'b0, d}) : rs[DW-1:0];
    r.nb  = x.nb << 1;
    r.q   = {x.q[QW-2:0], ge};
    r.ovf = x.ovf;
    return r;
  endfunction

  logic          vld_q   [0:QW];
  side_t         side_q  [0:QW];
  logic [DW-1:0] d_q     [0:QW];
  lane_t         lane0_q [0:QW];
  lane_t         lane1_q [0:QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0]  <= side_i;
      d_q[0]     <= d_i;
      lane0_q[0] <= load(n0_i, d_i);
      lane1_q[0] <= load(n1_i, d_i);
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s]  <= side_q[s-1];
        d_q[s]     <= d_q[s-1];
        lane0_q[s] <= step(lane0_q[s-1], d_q[s-1]);
        lane1_q[s] <= step(lane1_q[s-1], d_q[s-1]);
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign side_o  = side_q[QW];
  assign q0_o    = lane0_q[QW].q;
  assign q1_o    = lane1_q[QW].q;
  assign ovf0_o  = lane0_q[QW].ovf;
  assign ovf1_o  = lane1_q[QW].ovf;

endmodule

`default_nettype wire

// ===== sv/line_circle_nearest_intersection_unit.sv =====
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    in_data_i   (line_t)
// out      output     out_valid_o / out_ready_i  out_data_o  (hit_t)
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One line is taken per cycle while the output is not stalled. The square root
// and divider each resolve one bit per stage.
// Reset clears the valid bits and the circle registers.
// A stalled output freezes every stage, so the input is ready only while the
// output register is empty or output ready is high.

module line_circle_nearest_intersection_unit #(
  parameter int unsigned MUL_DIGIT = lcni_pkg::MUL_DIGIT_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  lcni_pkg::line_t          in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output lcni_pkg::hit_t           out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  lcni_pkg::cfg_index_e     cfg_index_i,
  input  lcni_pkg::coord_t         cfg_data_i
);

  import lcni_pkg::*;

  localparam int unsigned SW = MAG_WIDTH + 1;
  localparam int unsigned NW = MAG_WIDTH + 2;
  localparam int unsigned HW = COORD_WIDTH + 3;

  typedef logic signed [DIFF_WIDTH-1:0] diff_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;
  typedef logic [MAG_WIDTH-1:0]         mag_t;

  typedef struct packed {
    coord_t sx, sy;
    diff_t  dx, dy, fx, fy, rx, ry;
  } a_t;

  typedef struct packed {
    coord_t sx, sy;
    diff_t  dx, dy;
    prod_t  dxx, dyy, fxdx, fydy, fxdy, fydx, rxx, ryy;
  } b_t;

  typedef struct packed {
    coord_t sx, sy;
    diff_t  dx, dy;
    mag_t   a;
    mag_t   pmag;
    logic   pn;
  } m1_side_t;

  typedef struct packed {
    m1_side_t base;
    status_e  status;
  } sq_side_t;

  typedef struct packed {
    coord_t  sx, sy;
    logic    negx, negy;
    mag_t    a;
    status_e status;
  } m2_side_t;

  typedef struct packed {
    coord_t  sx, sy;
    logic    negx, negy;
    status_e status;
  } dv_side_t;

  function automatic coord_t place(coord_t st, logic [QUOT_WIDTH-1:0] q, logic ovf,
                                   logic neg);
    logic [QUOT_WIDTH:0]   qm;
    logic signed [HW-1:0]  qv;
    logic signed [HW-1:0]  sum;
    coord_t                r;
    qm  = ovf ? {1'b1, {QUOT_WIDTH{1'b0}}} : {1'b0, q};
    qv  = neg ? -$signed(HW'(qm)) : $signed(HW'(qm));
    sum = HW'(st) + qv;
    if (!sum[HW-1] && (|sum[HW-2:COORD_WIDTH-1])) begin
      r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else if (sum[HW-1] && !(&sum[HW-2:COORD_WIDTH-1])) begin
      r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      r = sum[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

  logic adv;

  coord_t centre_x_q, centre_y_q, rim_x_q, rim_y_q;

  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q, e_vld_q, out_vld_q;
  a_t   a_d, a_q;
  b_t   b_d, b_q;
  m1_side_t c_d, c_q;
  mag_t     c_r2_d, c_r2_q, c_crmag_d, c_crmag_q;

  logic                  m1_vld;
  m1_side_t              m1_side;
  logic [DISC_WIDTH-1:0] ar2, cr2;

  sq_side_t              d_side_d, d_side_q;
  logic [DISC_WIDTH-1:0] d_disc_d, d_disc_q;

  logic     sq_vld;
  sq_side_t sq_side;
  mag_t     sq_root;

  m2_side_t                e_side_d, e_side_q;
  mag_t                    e_num_d, e_num_q;
  logic [DIFF_WIDTH-1:0]   e_dxmag_d, e_dxmag_q, e_dymag_d, e_dymag_q;

  logic                   m2_vld;
  m2_side_t               m2_side;
  logic [NUMER_WIDTH-1:0] nx, ny;

  logic                  dv_vld;
  dv_side_t              dv_side;
  logic [QUOT_WIDTH-1:0] qx, qy;
  logic                  ovfx, ovfy;

  hit_t out_d, out_q;

  assign adv         = !out_vld_q || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q <= '0;
      centre_y_q <= '0;
      rim_x_q    <= '0;
      rim_y_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CENTRE_X: centre_x_q <= cfg_data_i;
        CFG_CENTRE_Y: centre_y_q <= cfg_data_i;
        CFG_RIM_X:    rim_x_q    <= cfg_data_i;
        CFG_RIM_Y:    rim_y_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    a_d.sx = in_data_i.start_x;
    a_d.sy = in_data_i.start_y;
    a_d.dx = DIFF_WIDTH'(in_data_i.end_x) - DIFF_WIDTH'(in_data_i.start_x);
    a_d.dy = DIFF_WIDTH'(in_data_i.end_y) - DIFF_WIDTH'(in_data_i.start_y);
    a_d.fx = DIFF_WIDTH'(in_data_i.start_x) - DIFF_WIDTH'(centre_x_q);
    a_d.fy = DIFF_WIDTH'(in_data_i.start_y) - DIFF_WIDTH'(centre_y_q);
    a_d.rx = DIFF_WIDTH'(rim_x_q) - DIFF_WIDTH'(centre_x_q);
    a_d.ry = DIFF_WIDTH'(rim_y_q) - DIFF_WIDTH'(centre_y_q);
  end

  always_comb begin
    b_d.sx   = a_q.sx;
    b_d.sy   = a_q.sy;
    b_d.dx   = a_q.dx;
    b_d.dy   = a_q.dy;
    b_d.dxx  = prod_t'(a_q.dx) * prod_t'(a_q.dx);
    b_d.dyy  = prod_t'(a_q.dy) * prod_t'(a_q.dy);
    b_d.fxdx = prod_t'(a_q.fx) * prod_t'(a_q.dx);
    b_d.fydy = prod_t'(a_q.fy) * prod_t'(a_q.dy);
    b_d.fxdy = prod_t'(a_q.fx) * prod_t'(a_q.dy);
    b_d.fydx = prod_t'(a_q.fy) * prod_t'(a_q.dx);
    b_d.rxx  = prod_t'(a_q.rx) * prod_t'(a_q.rx);
    b_d.ryy  = prod_t'(a_q.ry) * prod_t'(a_q.ry);
  end

  always_comb begin
    logic signed [SW-1:0] p;
    logic signed [SW-1:0] cr;
    p           = SW'(b_q.fxdx) + SW'(b_q.fydy);
    cr          = SW'(b_q.fxdy) - SW'(b_q.fydx);
    c_d.sx      = b_q.sx;
    c_d.sy      = b_q.sy;
    c_d.dx      = b_q.dx;
    c_d.dy      = b_q.dy;
    c_d.a       = MAG_WIDTH'($unsigned(b_q.dxx)) + MAG_WIDTH'($unsigned(b_q.dyy));
    c_d.pn      = p[SW-1];
    c_d.pmag    = p[SW-1] ? MAG_WIDTH'(-p) : MAG_WIDTH'(p);
    c_crmag_d   = cr[SW-1] ? MAG_WIDTH'(-cr) : MAG_WIDTH'(cr);
    c_r2_d      = MAG_WIDTH'($unsigned(b_q.rxx)) + MAG_WIDTH'($unsigned(b_q.ryy));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      e_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q   <= in_valid_i;
      b_vld_q   <= a_vld_q;
      c_vld_q   <= b_vld_q;
      d_vld_q   <= m1_vld;
      e_vld_q   <= sq_vld;
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q       <= a_d;
      b_q       <= b_d;
      c_q       <= c_d;
      c_r2_q    <= c_r2_d;
      c_crmag_q <= c_crmag_d;
      d_side_q  <= d_side_d;
      d_disc_q  <= d_disc_d;
      e_side_q  <= e_side_d;
      e_num_q   <= e_num_d;
      e_dxmag_q <= e_dxmag_d;
      e_dymag_q <= e_dymag_d;
      out_q     <= out_d;
    end
  end

  lcni_mul2 #(
    .WA(MAG_WIDTH), .WB(MAG_WIDTH), .DIG(MUL_DIGIT), .side_t(m1_side_t)
  ) u_mul_disc (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(c_vld_q), .side_i(c_q),
    .a0_i(c_q.a), .b0_i(c_r2_q), .a1_i(c_crmag_q), .b1_i(c_crmag_q),
    .valid_o(m1_vld), .side_o(m1_side), .p0_o(ar2), .p1_o(cr2)
  );

  always_comb begin
    d_side_d.base = m1_side;
    if (m1_side.a == '0) begin
      d_side_d.status = STATUS_ZERO_LINE;
    end else if (ar2 < cr2) begin
      d_side_d.status = STATUS_NO_HIT;
    end else if (ar2 == cr2) begin
      d_side_d.status = STATUS_TANGENT;
    end else begin
      d_side_d.status = STATUS_TWO_ROOTS;
    end
    d_disc_d = ar2 - cr2;
  end

  lcni_sqrt #(
    .VW(DISC_WIDTH), .side_t(sq_side_t)
  ) u_sqrt (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(d_vld_q), .side_i(d_side_q), .value_i(d_disc_q),
    .valid_o(sq_vld), .side_o(sq_side), .root_o(sq_root)
  );

  always_comb begin
    logic                 sn;
    logic signed [NW-1:0] mp;
    logic signed [NW-1:0] ms;
    logic signed [NW-1:0] num;
    logic                 numn;
    logic                 dxn;
    logic                 dyn;
    sn   = sq_side.base.pn && (sq_side.base.pmag > sq_side.base.a);
    mp   = sq_side.base.pn ? $signed(NW'(sq_side.base.pmag))
                           : -$signed(NW'(sq_side.base.pmag));
    ms   = sn ? -$signed(NW'(sq_root)) : $signed(NW'(sq_root));
    num  = mp + ms;
    numn = num[NW-1];
    dxn  = sq_side.base.dx[DIFF_WIDTH-1];
    dyn  = sq_side.base.dy[DIFF_WIDTH-1];
    e_num_d         = numn ? MAG_WIDTH'(-num) : MAG_WIDTH'(num);
    e_dxmag_d       = dxn ? DIFF_WIDTH'(-sq_side.base.dx) : DIFF_WIDTH'(sq_side.base.dx);
    e_dymag_d       = dyn ? DIFF_WIDTH'(-sq_side.base.dy) : DIFF_WIDTH'(sq_side.base.dy);
    e_side_d.sx     = sq_side.base.sx;
    e_side_d.sy     = sq_side.base.sy;
    e_side_d.negx   = numn ^ dxn;
    e_side_d.negy   = numn ^ dyn;
    e_side_d.a      = sq_side.base.a;
    e_side_d.status = sq_side.status;
  end

  lcni_mul2 #(
    .WA(MAG_WIDTH), .WB(DIFF_WIDTH), .DIG(MUL_DIGIT), .side_t(m2_side_t)
  ) u_mul_step (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(e_vld_q), .side_i(e_side_q),
    .a0_i(e_num_q), .b0_i(e_dxmag_q), .a1_i(e_num_q), .b1_i(e_dymag_q),
    .valid_o(m2_vld), .side_o(m2_side), .p0_o(nx), .p1_o(ny)
  );

  lcni_div2 #(
    .NW(NUMER_WIDTH), .DW(MAG_WIDTH), .QW(QUOT_WIDTH), .side_t(dv_side_t)
  ) u_div (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(m2_vld),
    .side_i('{sx: m2_side.sx, sy: m2_side.sy, negx: m2_side.negx, negy: m2_side.negy,
              status: m2_side.status}),
    .n0_i(nx), .n1_i(ny), .d_i(m2_side.a),
    .valid_o(dv_vld), .side_o(dv_side), .q0_o(qx), .q1_o(qy),
    .ovf0_o(ovfx), .ovf1_o(ovfy)
  );

  always_comb begin
    out_d.status = dv_side.status;
    if (dv_side.status == STATUS_NO_HIT || dv_side.status == STATUS_ZERO_LINE) begin
      out_d.hit_x = '0;
      out_d.hit_y = '0;
    end else begin
      out_d.hit_x = place(dv_side.sx, qx, ovfx, dv_side.negx);
      out_d.hit_y = place(dv_side.sy, qy, ovfy, dv_side.negy);
    end
  end

endmodule

`default_nettype wire
